// ===== sv/dlstq_pkg.sv =====
// Shared types and constants for the delta-list sleep timer queue.
// No dependencies; imported by dlstq_ram users and the top level.
package dlstq_pkg;

    localparam int MAX_SLEEPERS = 32;
    localparam int IDX_W        = $clog2(MAX_SLEEPERS);
    localparam int CNT_W        = $clog2(MAX_SLEEPERS + 1);
    localparam int ID_W         = 8;
    localparam int DELTA_W      = 16;
    localparam int SUM_W        = DELTA_W + IDX_W;

    typedef logic [1:0] func_t;
    localparam func_t FUNC_INSERT   = 2'd0;
    localparam func_t FUNC_TICK     = 2'd1;
    localparam func_t FUNC_CANCEL   = 2'd2;
    localparam func_t FUNC_RESERVED = 2'd3;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_INSERT  = 2'd0;
    localparam kind_t KIND_CANCEL  = 2'd1;
    localparam kind_t KIND_EXPIRED = 2'd2;

    typedef struct packed {
        func_t              func;
        logic [ID_W-1:0]    thread_id;
        logic [DELTA_W-1:0] sleep_ticks;
        logic               defer_expiry;
    } req_t;

    typedef struct packed {
        kind_t           kind;
        logic [ID_W-1:0] thread_id_res;
        logic            ok;
        logic            last;
    } rsp_t;

endpackage

// ===== sv/dlstq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dlstq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/delta_list_sleep_timer_queue.sv =====
// Top level of the delta-list sleep timer queue.
// Depends on dlstq_pkg and three dlstq_ram instances (id, delta, next link).
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one command beat: insert a
//   sleeper, timer tick, or cancel a sleeper by id. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns result beats; every beat caused by one
//   command has last set on its final beat.
//   Insert and cancel always answer with one beat. A tick answers with one
//   beat per expired sleeper, or with nothing when none expired or when
//   defer_expiry is set. Command value 3 is dropped without an answer.
// Throughput:
//   One command is worked at a time. The list walk reads one linked entry per
//   cycle from the registered-read memories, but a tick walk holds while an
//   expired sleeper waits for the full output register. The walk goes over
//   the linked list through the single read port.
// Reset:
//   rst_n clears the list (count, head, tail, tail total, slot usage map).
//   The entry memories need no clearing pass; the block is ready for a
//   command as soon as reset is released.
// Stalls:
//   A finished beat waits in the output register while the block goes on;
//   a tick that has more expired sleepers to report holds until rsp_ready.
module delta_list_sleep_timer_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  dlstq_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output dlstq_pkg::rsp_t rsp
);
    import dlstq_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        INS_WALK,
        INS_FIN,
        CAN_WALK,
        CAN_FOLD,
        TICK_CHK,
        RESP
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [IDX_W-1:0]        tail_reg, tail_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [DELTA_W-1:0]      total_reg, total_next;
    logic [MAX_SLEEPERS-1:0] used_reg, used_next;
    logic [IDX_W-1:0]        cur_reg, cur_next;
    logic [IDX_W-1:0]        prev_reg, prev_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [CNT_W-1:0]        steps_reg, steps_next;
    logic [DELTA_W-1:0]      fold_reg, fold_next;
    logic                    head_case_reg, head_case_next;
    logic                    first_reg, first_next;
    logic                    pend_reg, pend_next;
    logic [ID_W-1:0]         pend_id_reg, pend_id_next;
    logic [ID_W-1:0]         tid_reg, tid_next;
    logic [DELTA_W-1:0]      tts_reg, tts_next;
    logic                    defer_reg, defer_next;
    kind_t                   kind_reg, kind_next;
    logic                    ok_reg, ok_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;

    // memory ports
    logic [IDX_W-1:0]   rd_addr;
    logic [ID_W-1:0]    rd_id;
    logic [DELTA_W-1:0] rd_delta;
    logic [IDX_W-1:0]   rd_link;
    logic               id_we, delta_we, link_we;
    logic [IDX_W-1:0]   id_waddr, delta_waddr, link_waddr;
    logic [ID_W-1:0]    id_wdata;
    logic [DELTA_W-1:0] delta_wdata;
    logic [IDX_W-1:0]   link_wdata;

    logic               can_load;
    logic [IDX_W-1:0]   free_slot;
    logic [SUM_W-1:0]   full_sum;
    logic [SUM_W-1:0]   tts_ext;
    logic [DELTA_W-1:0] d_eff;
    logic [DELTA_W:0]   fold_sum;

    dlstq_ram #(.WIDTH(ID_W), .DEPTH(MAX_SLEEPERS)) u_id_ram (
        .clk   (clk),
        .we    (id_we),
        .waddr (id_waddr),
        .wdata (id_wdata),
        .raddr (rd_addr),
        .rdata (rd_id)
    );

    dlstq_ram #(.WIDTH(DELTA_W), .DEPTH(MAX_SLEEPERS)) u_delta_ram (
        .clk   (clk),
        .we    (delta_we),
        .waddr (delta_waddr),
        .wdata (delta_wdata),
        .raddr (rd_addr),
        .rdata (rd_delta)
    );

    dlstq_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SLEEPERS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_addr),
        .rdata (rd_link)
    );

    // lowest slot not on the list
    always_comb
    begin
        free_slot = '0;
        for (int i = MAX_SLEEPERS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = IDX_W'(i);
            end
        end
    end

    assign can_load  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign tts_ext   = SUM_W'(tts_reg);
    assign full_sum  = sum_reg + SUM_W'(rd_delta);
    assign fold_sum  = {1'b0, rd_delta} + {1'b0, fold_reg};
    assign d_eff     = (first_reg && rd_delta != '0) ? rd_delta - DELTA_W'(1) :
                       (first_reg ? '0 : rd_delta);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        used_next      = used_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        sum_next       = sum_reg;
        steps_next     = steps_reg;
        fold_next      = fold_reg;
        head_case_next = head_case_reg;
        first_next     = first_reg;
        pend_next      = pend_reg;
        pend_id_next   = pend_id_reg;
        tid_next       = tid_reg;
        tts_next       = tts_reg;
        defer_next     = defer_reg;
        kind_next      = kind_reg;
        ok_next        = ok_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        rd_addr     = cur_reg;
        id_we       = 1'b0;
        id_waddr    = free_slot;
        id_wdata    = tid_reg;
        delta_we    = 1'b0;
        delta_waddr = free_slot;
        delta_wdata = '0;
        link_we     = 1'b0;
        link_waddr  = free_slot;
        link_wdata  = cur_reg;

        case (state_reg)
            IDLE:
            begin
                if (req_valid)
                begin
                    tid_next   = req.thread_id;
                    tts_next   = req.sleep_ticks;
                    defer_next = req.defer_expiry;
                    case (req.func)
                        FUNC_INSERT:
                        begin
                            kind_next = KIND_INSERT;
                            ok_next   = 1'b1;
                            id_wdata  = req.thread_id;
                            if (cnt_reg >= CNT_W'(MAX_SLEEPERS))
                            begin
                                ok_next    = 1'b0;
                                state_next = RESP;
                            end
                            else if (cnt_reg == '0)
                            begin
                                id_we       = 1'b1;
                                delta_we    = 1'b1;
                                delta_wdata = req.sleep_ticks;
                                head_next   = free_slot;
                                tail_next   = free_slot;
                                total_next  = req.sleep_ticks;
                                cnt_next    = cnt_reg + CNT_W'(1);
                                used_next[free_slot] = 1'b1;
                                state_next  = RESP;
                            end
                            else if (req.sleep_ticks >= total_reg)
                            begin
                                // append behind the tail
                                id_we       = 1'b1;
                                delta_we    = 1'b1;
                                delta_wdata = req.sleep_ticks - total_reg;
                                link_we     = 1'b1;
                                link_waddr  = tail_reg;
                                link_wdata  = free_slot;
                                tail_next   = free_slot;
                                total_next  = req.sleep_ticks;
                                cnt_next    = cnt_reg + CNT_W'(1);
                                used_next[free_slot] = 1'b1;
                                state_next  = RESP;
                            end
                            else
                            begin
                                rd_addr    = head_reg;
                                cur_next   = head_reg;
                                prev_next  = head_reg;
                                sum_next   = '0;
                                steps_next = '0;
                                state_next = INS_WALK;
                            end
                        end
                        FUNC_TICK:
                        begin
                            if (total_reg != '0)
                            begin
                                total_next = total_reg - DELTA_W'(1);
                            end
                            if (cnt_reg != '0)
                            begin
                                rd_addr    = head_reg;
                                cur_next   = head_reg;
                                first_next = 1'b1;
                                pend_next  = 1'b0;
                                state_next = TICK_CHK;
                            end
                        end
                        FUNC_CANCEL:
                        begin
                            kind_next = KIND_CANCEL;
                            ok_next   = 1'b0;
                            if (cnt_reg == '0)
                            begin
                                state_next = RESP;
                            end
                            else
                            begin
                                rd_addr    = head_reg;
                                cur_next   = head_reg;
                                prev_next  = head_reg;
                                steps_next = '0;
                                state_next = CAN_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = IDLE;
                        end
                    endcase
                end
            end

            INS_WALK:
            begin
                if (tts_ext >= full_sum &&
                    ({1'b0, steps_reg} + (CNT_W+1)'(1)) < {1'b0, cnt_reg})
                begin
                    // advance to the next entry
                    prev_next  = cur_reg;
                    cur_next   = rd_link;
                    rd_addr    = rd_link;
                    sum_next   = full_sum;
                    steps_next = steps_reg + CNT_W'(1);
                end
                else if (tts_ext >= full_sum)
                begin
                    id_we       = 1'b1;
                    delta_we    = 1'b1;
                    delta_wdata = DELTA_W'(tts_ext - full_sum);
                    link_we     = 1'b1;
                    link_waddr  = tail_reg;
                    link_wdata  = free_slot;
                    tail_next   = free_slot;
                    cnt_next    = cnt_reg + CNT_W'(1);
                    used_next[free_slot] = 1'b1;
                    ok_next     = 1'b1;
                    state_next  = RESP;
                end
                else
                begin
                    // split the delta of the current entry
                    id_we          = 1'b1;
                    delta_we       = 1'b1;
                    delta_wdata    = DELTA_W'(tts_ext - sum_reg);
                    link_we        = 1'b1;
                    link_wdata     = cur_reg;
                    fold_next      = DELTA_W'(full_sum - tts_ext);
                    head_case_next = (steps_reg == '0);
                    state_next     = INS_FIN;
                end
            end

            INS_FIN:
            begin
                delta_we    = 1'b1;
                delta_waddr = cur_reg;
                delta_wdata = fold_reg;
                if (head_case_reg)
                begin
                    head_next = free_slot;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg;
                    link_wdata = free_slot;
                end
                cnt_next   = cnt_reg + CNT_W'(1);
                used_next[free_slot] = 1'b1;
                ok_next    = 1'b1;
                state_next = RESP;
            end

            CAN_WALK:
            begin
                if (rd_id == tid_reg)
                begin
                    ok_next = 1'b1;
                    if (steps_reg == '0)
                    begin
                        head_next = rd_link;
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg;
                        link_wdata = rd_link;
                    end
                    cnt_next = cnt_reg - CNT_W'(1);
                    used_next[cur_reg] = 1'b0;
                    if (cur_reg == tail_reg)
                    begin
                        tail_next  = (steps_reg == '0) ? '0 : prev_reg;
                        total_next = (total_reg > rd_delta) ? total_reg - rd_delta : '0;
                        if (cnt_reg == CNT_W'(1))
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            total_next = '0;
                        end
                        state_next = RESP;
                    end
                    else
                    begin
                        // fold the removed delta into the successor
                        fold_next  = rd_delta;
                        cur_next   = rd_link;
                        rd_addr    = rd_link;
                        state_next = CAN_FOLD;
                    end
                end
                else if (({1'b0, steps_reg} + (CNT_W+1)'(1)) < {1'b0, cnt_reg})
                begin
                    prev_next  = cur_reg;
                    cur_next   = rd_link;
                    rd_addr    = rd_link;
                    steps_next = steps_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = RESP;
                end
            end

            CAN_FOLD:
            begin
                delta_we    = 1'b1;
                delta_waddr = cur_reg;
                delta_wdata = fold_sum[DELTA_W] ? '1 : fold_sum[DELTA_W-1:0];
                state_next  = RESP;
            end

            TICK_CHK:
            begin
                if (first_reg)
                begin
                    first_next = 1'b0;
                    if (rd_delta != '0)
                    begin
                        delta_we    = 1'b1;
                        delta_waddr = cur_reg;
                        delta_wdata = rd_delta - DELTA_W'(1);
                    end
                end
                if (first_reg && defer_reg)
                begin
                    state_next = IDLE;
                end
                else if (cnt_reg != '0 && d_eff == '0)
                begin
                    if (!(pend_reg && !can_load))
                    begin
                        if (pend_reg)
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next       = '{KIND_EXPIRED, pend_id_reg, 1'b1, 1'b0};
                        end
                        // pop the head and look at its successor
                        pend_next    = 1'b1;
                        pend_id_next = rd_id;
                        head_next    = rd_link;
                        cur_next     = rd_link;
                        rd_addr      = rd_link;
                        cnt_next     = cnt_reg - CNT_W'(1);
                        used_next[cur_reg] = 1'b0;
                    end
                end
                else if (!(pend_reg && !can_load))
                begin
                    if (pend_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = '{KIND_EXPIRED, pend_id_reg, 1'b1, 1'b1};
                    end
                    pend_next = 1'b0;
                    if (cnt_reg == '0)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        total_next = '0;
                    end
                    state_next = IDLE;
                end
            end

            RESP:
            begin
                if (can_load)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{kind_reg, tid_reg, ok_reg, 1'b1};
                    state_next     = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            used_reg      <= '0;
            first_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            used_reg      <= used_next;
            first_reg     <= first_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        sum_reg       <= sum_next;
        steps_reg     <= steps_next;
        fold_reg      <= fold_next;
        head_case_reg <= head_case_next;
        pend_id_reg   <= pend_id_next;
        tid_reg       <= tid_next;
        tts_reg       <= tts_next;
        defer_reg     <= defer_next;
        kind_reg      <= kind_next;
        ok_reg        <= ok_next;
        rsp_reg       <= rsp_next;
    end

    // the slot usage map and the entry count track the same list
    a_used_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == int'(cnt_reg))
        else $error("slot usage map disagrees with entry count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_SLEEPERS))
        else $error("entry count beyond capacity");

    a_empty_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == IDLE && cnt_reg == '0) |->
        (head_reg == '0 && tail_reg == '0 && total_reg == '0))
        else $error("empty list left stale head, tail or total");

    a_pend_only_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == TICK_CHK)
        else $error("expired sleeper held outside the tick walk");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == TICK_CHK && state_next == IDLE) |=> !pend_reg)
        else $error("tick finished with an unreported sleeper");

endmodule
